### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the eigenvalue ranker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WTK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define WTK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/wtk_pkg.sv
// ----------------------------------------------------------------------------
// Eigenvalue ranker package
// Shared constants, codes and control types of the windowed top-k ranker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wtk_pkg;

  // Default sizes
  localparam int KEEP_MAX_DEF   = 16;
  localparam int EV_MAX_DEF     = 1024;
  localparam int VALUE_BITS_DEF = 32;

  // Result field widths
  localparam int RIDX_W = 10;
  localparam int RPOS_W = 4;
  localparam int OUT_DW = 16;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 5;
  localparam int KEEP_W = 5;

  typedef enum logic [CFG_AW-1:0] {
    REG_BRANCH  = 2'd0,
    REG_PROBLEM = 2'd1,
    REG_KEEP    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    BR_TEMPORAL = 1'b0,
    BR_SPATIAL  = 1'b1
  } branch_t;

  typedef enum logic [1:0] {
    PK_POISEUILLE = 2'd0,
    PK_COUETTE    = 2'd1,
    PK_BLAYER     = 2'd2,
    PK_OTHER      = 2'd3
  } problem_t;

  localparam logic [KEEP_W-1:0] KEEP_RST = 5'd16;

  // Window limits, Q16.16
  localparam logic signed [31:0] LIM_0P8 = 32'sd52428;
  localparam logic signed [31:0] LIM_1P5 = 32'sd98304;
  localparam logic signed [31:0] LIM_20  = 32'sd1310720;
  localparam logic signed [31:0] LIM_M1  = -32'sd65536;
  localparam logic signed [31:0] LIM_1   = 32'sd65536;
  localparam logic signed [31:0] LIM_2   = 32'sd131072;

  typedef enum logic {
    S_RUN  = 1'b0,
    S_EMIT = 1'b1
  } state_t;

  // Ordering rule handed to every cell
  typedef struct packed {
    logic imag_desc;
    logic real_desc;
    logic no_sort;
  } order_t;

  // Per-cycle command broadcast along the chain
  typedef struct packed {
    logic   ins;
    logic   drain;
    logic   clr;
    order_t ord;
  } cell_ctl_t;

endpackage

`default_nettype wire

### sv/wtk_rule.sv
// ----------------------------------------------------------------------------
// Window and order rule
// Decides whether an eigenvalue passes the case window and which order
// the insertion chain applies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtk_rule
  import wtk_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         branch,
  input  wire logic [1:0]                   problem,
  input  wire logic signed [VALUE_BITS-1:0] ev_re,
  input  wire logic signed [VALUE_BITS-1:0] ev_im,
  output logic                              pass,
  output order_t                            ord
);

  localparam int CMP_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  logic signed [CMP_W-1:0] re_x;
  logic signed [CMP_W-1:0] im_x;
  logic signed [CMP_W-1:0] l_0p8, l_1p5, l_20, l_m1, l_1, l_2;

  // Widen values and limits to a common signed width
  assign re_x  = CMP_W'(ev_re);
  assign im_x  = CMP_W'(ev_im);
  assign l_0p8 = CMP_W'(LIM_0P8);
  assign l_1p5 = CMP_W'(LIM_1P5);
  assign l_20  = CMP_W'(LIM_20);
  assign l_m1  = CMP_W'(LIM_M1);
  assign l_1   = CMP_W'(LIM_1);
  assign l_2   = CMP_W'(LIM_2);

  // Window per branch and problem
  always_comb begin
    pass = 1'b0;
    if (branch == BR_TEMPORAL) begin
      case (problem)
        PK_POISEUILLE, PK_COUETTE: pass = 1'b1;
        PK_BLAYER:                 pass = (re_x <= l_0p8);
        default:                   pass = 1'b0;
      endcase
    end else begin
      case (problem)
        PK_POISEUILLE: pass = (im_x > l_m1) && (im_x < l_2);
        PK_COUETTE:    pass = (im_x >= 0) && (re_x >= 0);
        PK_BLAYER:     pass = (im_x > l_m1) && (im_x < l_1) &&
                              (re_x > l_1p5) && (re_x < l_20);
        default:       pass = 1'b1;
      endcase
    end
  end

  // Sort directions per case
  always_comb begin
    ord.imag_desc = (branch == BR_TEMPORAL);
    ord.no_sort   = (branch == BR_SPATIAL) && (problem == PK_OTHER);
    if (branch == BR_TEMPORAL) begin
      ord.real_desc = (problem == PK_POISEUILLE) || (problem == PK_COUETTE);
    end else begin
      ord.real_desc = (problem != PK_COUETTE);
    end
  end

endmodule

`default_nettype wire

### sv/wtk_cell.sv
// ----------------------------------------------------------------------------
// Insertion cell
// One slot of the sorted chain: compares the broadcast item with its entry,
// takes the new item, its left neighbor's entry, or its right neighbor's.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtk_cell
  import wtk_pkg::*;
#(
  parameter int IDX_W      = 10,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cell_ctl_t                    ctl,
  // broadcast item
  input  wire logic [IDX_W-1:0]             new_idx,
  input  wire logic signed [VALUE_BITS-1:0] new_re,
  input  wire logic signed [VALUE_BITS-1:0] new_im,
  // position search
  input  wire logic                         found_in,
  output logic                              found_out,
  // left neighbor (shift on insert)
  input  wire logic                         l_vld,
  input  wire logic [IDX_W-1:0]             l_idx,
  input  wire logic signed [VALUE_BITS-1:0] l_re,
  input  wire logic signed [VALUE_BITS-1:0] l_im,
  // right neighbor (shift on drain)
  input  wire logic                         r_vld,
  input  wire logic [IDX_W-1:0]             r_idx,
  input  wire logic signed [VALUE_BITS-1:0] r_re,
  input  wire logic signed [VALUE_BITS-1:0] r_im,
  // own entry
  output logic                              vld_o,
  output logic [IDX_W-1:0]                  idx_o,
  output logic signed [VALUE_BITS-1:0]      re_o,
  output logic signed [VALUE_BITS-1:0]      im_o
);

  logic                         vld_r, vld_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic signed [VALUE_BITS-1:0] re_r, re_nxt;
  logic signed [VALUE_BITS-1:0] im_r, im_nxt;
  logic                         ahead;
  logic                         take_new;

  // New item ranks strictly ahead of this entry
  always_comb begin
    ahead = 1'b0;
    if (!ctl.ord.no_sort) begin
      if (new_im != im_r) begin
        ahead = ctl.ord.imag_desc ? (new_im > im_r) : (new_im < im_r);
      end else if (new_re != re_r) begin
        ahead = ctl.ord.real_desc ? (new_re > re_r) : (new_re < re_r);
      end
    end
  end

  // First free or out-ranked slot takes the item; all after it shift
  assign take_new  = !found_in && (!vld_r || ahead);
  assign found_out = found_in || !vld_r || ahead;

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    re_nxt  = re_r;
    im_nxt  = im_r;
    if (ctl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctl.drain) begin
      vld_nxt = r_vld;
      idx_nxt = r_idx;
      re_nxt  = r_re;
      im_nxt  = r_im;
    end else if (ctl.ins) begin
      if (found_in) begin
        vld_nxt = l_vld;
        idx_nxt = l_idx;
        re_nxt  = l_re;
        im_nxt  = l_im;
      end else if (take_new) begin
        vld_nxt = 1'b1;
        idx_nxt = new_idx;
        re_nxt  = new_re;
        im_nxt  = new_im;
      end
    end
  end

  // Valid bit clears on reset; payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    re_r  <= re_nxt;
    im_r  <= im_nxt;
  end

  assign vld_o = vld_r;
  assign idx_o = idx_r;
  assign re_o  = re_r;
  assign im_o  = im_r;

endmodule

`default_nettype wire

### sv/windowed_top_k_eigenvalue_ranker.sv
// ----------------------------------------------------------------------------
// Windowed top-k eigenvalue ranker
// Filters complex eigenvalues by a case window, keeps the best KEEP_MAX in
// a sorted chain of insertion cells and emits ranked arrival indices.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                                   | Handshake
// in_*    | in  | tdata re,im; tuser finite; tlast last     | tvalid/tready
// out_*   | out | tdata index,rank; tuser flags; tlast last | tvalid/tready
// cfg_*   | in  | addr, wdata                               | we, no wait
//
// One item is taken per cycle while a set streams in; each finite item that
// passes the window, within EV_MAX, enters the chain in the cycle it is accepted.
// After the item marked last, in_tready stays low while the chain shifts
// out one result per cycle: min(kept, keep_count) results, or one status.
// A stalled out_tready holds the chain; the next set starts after the last
// result transfer. Synchronous reset clears chain and counters, defaults config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_top_k_eigenvalue_ranker
  import wtk_pkg::*;
#(
  parameter int KEEP_MAX   = KEEP_MAX_DEF,
  parameter int EV_MAX     = EV_MAX_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IN_DW     = ((2 * VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // ev_real, ev_imag, zero pad
  input  wire logic              in_tuser,   // ev_finite
  input  wire logic              in_tlast,   // last_item
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // ranked_index, rank_position, pad
  output logic [2:0]             out_tuser,  // nothing_kept, unsupported, too_many
  output logic                   out_tlast,  // last_result
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  localparam int IDX_W = (EV_MAX > 1) ? $clog2(EV_MAX) : 1;
  localparam int CNT_W = $clog2(EV_MAX + 1);
  localparam int RK_W  = $clog2(KEEP_MAX + 1);

  // Configuration registers
  logic              branch_r, branch_nxt;
  logic [1:0]        problem_r, problem_nxt;
  logic [KEEP_W-1:0] keep_r, keep_nxt;

  always_comb begin
    branch_nxt  = branch_r;
    problem_nxt = problem_r;
    keep_nxt    = keep_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_BRANCH:  branch_nxt  = cfg_wdata[0];
        REG_PROBLEM: problem_nxt = cfg_wdata[1:0];
        REG_KEEP:    keep_nxt    = cfg_wdata[KEEP_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branch_r  <= BR_TEMPORAL;
      problem_r <= PK_POISEUILLE;
      keep_r    <= KEEP_RST;
    end else begin
      branch_r  <= branch_nxt;
      problem_r <= problem_nxt;
      keep_r    <= keep_nxt;
    end
  end

  // Input unpack
  logic signed [VALUE_BITS-1:0] ev_re, ev_im;
  assign ev_re = in_tdata[VALUE_BITS-1:0];
  assign ev_im = in_tdata[2*VALUE_BITS-1:VALUE_BITS];

  logic   win_pass;
  order_t ord;

  wtk_rule #(
    .VALUE_BITS (VALUE_BITS)
  ) u_rule (
    .branch  (branch_r),
    .problem (problem_r),
    .ev_re   (ev_re),
    .ev_im   (ev_im),
    .pass    (win_pass),
    .ord     (ord)
  );

  // Control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] arrival_r, arrival_nxt;
  logic             ovf_r, ovf_nxt;
  logic [RK_W-1:0]  rank_r, rank_nxt;

  logic in_xfer, out_xfer, has_room, ins, unsup;
  logic status, res_last;
  logic [RK_W-1:0] lim;
  cell_ctl_t ctl;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign has_room = (arrival_r < CNT_W'(EV_MAX));
  assign ins      = in_xfer && has_room && in_tuser && win_pass;
  assign unsup    = (branch_r == BR_TEMPORAL) && (problem_r == PK_OTHER);
  assign lim      = (32'(keep_r) > 32'(KEEP_MAX)) ? RK_W'(KEEP_MAX) : RK_W'(keep_r);

  // Cell chain wiring; slot KEEP_MAX is the empty end of the row
  logic                         c_vld [0:KEEP_MAX];
  logic [IDX_W-1:0]             c_idx [0:KEEP_MAX];
  logic signed [VALUE_BITS-1:0] c_re  [0:KEEP_MAX];
  logic signed [VALUE_BITS-1:0] c_im  [0:KEEP_MAX];
  // search flag entering cell g; fnd[KEEP_MAX] leaves the last cell
  logic                         fnd   [0:KEEP_MAX];
  logic [KEEP_MAX-1:0]          vld_vec;

  assign c_vld[KEEP_MAX] = 1'b0;
  assign c_idx[KEEP_MAX] = '0;
  assign c_re[KEEP_MAX]  = '0;
  assign c_im[KEEP_MAX]  = '0;
  assign fnd[0]          = 1'b0;

  assign ctl.ins   = ins;
  assign ctl.drain = out_xfer && !res_last;
  assign ctl.clr   = out_xfer && res_last;
  assign ctl.ord   = ord;

  for (genvar g = 0; g < KEEP_MAX; g++) begin : g_cell
    localparam int LFT = (g == 0) ? KEEP_MAX : g - 1;
    wtk_cell #(
      .IDX_W      (IDX_W),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_idx   (IDX_W'(arrival_r)),
      .new_re    (ev_re),
      .new_im    (ev_im),
      .found_in  (fnd[g]),
      .found_out (fnd[g+1]),
      .l_vld     (c_vld[LFT]),
      .l_idx     (c_idx[LFT]),
      .l_re      (c_re[LFT]),
      .l_im      (c_im[LFT]),
      .r_vld     (c_vld[g+1]),
      .r_idx     (c_idx[g+1]),
      .r_re      (c_re[g+1]),
      .r_im      (c_im[g+1]),
      .vld_o     (c_vld[g]),
      .idx_o     (c_idx[g]),
      .re_o      (c_re[g]),
      .im_o      (c_im[g])
    );
    assign vld_vec[g] = c_vld[g];
  end

  // Result selection at the head of the chain
  assign status   = (rank_r == '0) && (unsup || !c_vld[0] || (lim == '0));
  assign res_last = status || !c_vld[1] ||
                    ((RK_W+1)'(rank_r) + (RK_W+1)'(1) == (RK_W+1)'(lim));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RUN:   if (in_xfer && in_tlast) state_nxt = S_EMIT;
      S_EMIT:  if (out_xfer && res_last) state_nxt = S_RUN;
      default: state_nxt = S_RUN;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_RUN:   in_tready  = 1'b1;
      S_EMIT:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  // Arrival numbering, overflow and rank counter
  always_comb begin
    arrival_nxt = arrival_r;
    ovf_nxt     = ovf_r;
    rank_nxt    = rank_r;
    if (in_xfer) begin
      if (has_room) begin
        arrival_nxt = arrival_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (ctl.drain) begin
      rank_nxt = rank_r + RK_W'(1);
    end else if (ctl.clr) begin
      rank_nxt    = '0;
      arrival_nxt = '0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_RUN;
      arrival_r <= '0;
      ovf_r     <= 1'b0;
      rank_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      arrival_r <= arrival_nxt;
      ovf_r     <= ovf_nxt;
      rank_r    <= rank_nxt;
    end
  end

  // Result pack
  logic [RIDX_W-1:0] r_idx;
  logic [RPOS_W-1:0] r_pos;
  assign r_idx     = status ? '0 : RIDX_W'(c_idx[0]);
  assign r_pos     = status ? '0 : RPOS_W'(rank_r);
  assign out_tdata = {{(OUT_DW - RIDX_W - RPOS_W){1'b0}}, r_pos, r_idx};
  assign out_tuser = {ovf_r, status && unsup, status && (unsup || !c_vld[0])};
  assign out_tlast = res_last;

  // Checks
  `include "assert_macros.svh"

  `WTK_ASSERT(a_one_side, !(in_tready && out_tvalid), "input and result side both open")
  `WTK_ASSERT(a_prefix, ((vld_vec >> 1) & ~vld_vec) == '0, "kept entries not contiguous")
  `WTK_ASSERT(a_clear, out_xfer && res_last |=> vld_vec == '0, "chain not empty after run")
  `WTK_ASSERT(a_drop, ins && !fnd[KEEP_MAX] |=> $stable(vld_vec), "rejected item changed fill")

endmodule

`default_nettype wire
